[rtl/acm_pkg.sv]
// ----------------------------------------------------------------------------
// acm_pkg
// shared constants for the subband synthesis block
// ----------------------------------------------------------------------------
package acm_pkg;
  localparam int MAX_LEVELS = 8;
  localparam int MAX_ROWS   = 64;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_PENDING = 2'd2;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;
endpackage

[rtl/acm_subband_synthesis.sv]
// ----------------------------------------------------------------------------
// acm_subband_synthesis
// inverse subband filter for one chunk of audio, run in place in a memory
// ----------------------------------------------------------------------------
// s_axis transfers carry a request: tuser = req_type (0 push, 1 pull),
// tdata = sample_in (used on push). a push stores one sample in row-major
// order; the last push of a chunk starts synthesis over the sample memory.
// every pull, and a push refused while decoded output is pending, gives one
// m_axis transfer: tdata = sample_out, tlast = last_of_chunk, tuser = status.
// a plain push passes through S_WAIT; a refused push or an empty pull shows its
// result in the cycle after the transfer, a decoded pull after S_PULL takes the
// registered memory read; the next request is taken after the result drains.
// synthesis walks every sample pair once per level: two reads and two writes
// in S_RDA, S_RDB, S_WRA and S_WRB per pair per level, plus S_CLD0 to S_CLD2 and
// S_CST0, S_CST1 per column to fetch and store its two carries from the carry
// memory; the increment pass after the top level runs S_INCR and S_INCW per half-row.
// after reset a clearing pass zeroes the carry memory, one entry a cycle
// (2 << MAX_LEVELS entries, 512 by default) with s_axis_tready low; the sample
// memory is not cleared. while m_axis is stalled the block holds its result
// and accepts nothing more. apb writes are meant for idle times only.
// ----------------------------------------------------------------------------
module acm_subband_synthesis #(
  parameter int MAX_LEVELS = acm_pkg::MAX_LEVELS,
  parameter int MAX_ROWS   = acm_pkg::MAX_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_in
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // sample_out
  output logic        m_axis_tlast,   // last_of_chunk
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int LW  = $clog2(MAX_LEVELS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int RI  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int BW  = MAX_LEVELS;                  // column index width
  localparam int AW  = RI + MAX_LEVELS;             // sample address width
  localparam int CW  = AW + 1;                      // counts up to size
  localparam int DEPTH = MAX_ROWS << MAX_LEVELS;
  localparam int BMAX  = 1 << MAX_LEVELS;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_PULL  = 15'b000000000000010,
    S_RDA   = 15'b000000000000100,
    S_RDB   = 15'b000000000001000,
    S_WRA   = 15'b000000000010000,
    S_WRB   = 15'b000000000100000,
    S_CLD0  = 15'b000000001000000,
    S_CLD1  = 15'b000000010000000,
    S_CLD2  = 15'b000000100000000,
    S_CST0  = 15'b000001000000000,
    S_CST1  = 15'b000010000000000,
    S_INCR  = 15'b000100000000000,
    S_INCW  = 15'b001000000000000,
    S_WAIT  = 15'b010000000000000,
    S_CLR   = 15'b100000000000000
  } state_t;

  state_t state;

  logic [3:0] levels;
  logic [6:0] rows;
  logic [CW-1:0] push_count, pull_count;
  logic output_ready;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;
  logic        we;
  logic [AW-1:0] maddr;
  logic [31:0] wdata;

  // carry memory: top level carries in the lower half (kept sign-extended
  // from 16 bits), deeper level carries in the upper half
  logic [31:0] cmem [2*BMAX];
  logic [31:0] crdata;
  logic        cwe;
  logic [BW:0] caddr;
  logic [31:0] cwdata;
  logic [BW:0] clr_addr;

  // effective config
  logic [LW-1:0] lv;
  logic [RW-1:0] rw;
  logic [CW-1:0] size;
  always_comb begin
    lv = (levels > 4'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : LW'(levels);
    if (rows == 7'd0) rw = RW'(1);
    else if (32'(rows) > 32'(MAX_ROWS)) rw = RW'(MAX_ROWS);
    else rw = RW'(rows);
    size = CW'(rw) << lv;
  end

  // synthesis walk state
  logic [BW:0]   s;          // current stride
  logic [BW:0]   col;        // column within level
  logic [CW-1:0] pidx;       // pair index, half-row index in the increment pass
  logic [CW-1:0] pairs;
  logic [BW:0]   off;        // deep carry offset
  logic          top;
  logic [AW-1:0] idx;
  logic [31:0]   a, b, p0, p1;

  logic [BW:0] c0, c1;
  always_comb begin
    c0 = off + (col << 1);
    c1 = c0 + 1'b1;
  end

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      1'b0:    prdata = {28'd0, levels};
      default: prdata = {25'd0, rows};
    endcase
  end

  // no request transfer in the cycle of a register write
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid && !cfg_wr;
  logic acc;
  assign acc = s_axis_tvalid & s_axis_tready;

  // sample memory
  always_ff @(posedge clk) begin
    if (we) mem[maddr] <= wdata;
    rdata <= mem[maddr];
  end

  // carry memory
  always_ff @(posedge clk) begin
    if (cwe) cmem[caddr] <= cwdata;
    crdata <= cmem[caddr];
  end

  logic [31:0] even_v, odd_v;
  assign even_v = p0 + (p1 << 1) + a;
  assign odd_v  = (a << 1) - p1 - b;

  always_comb begin
    we = 1'b0;
    maddr = idx;
    wdata = rdata;
    case (state)
      S_IDLE: begin
        maddr = (acc && s_axis_tuser == acm_pkg::REQ_PULL) ? pull_count[AW-1:0]
                : (push_count >= size ? '0 : push_count[AW-1:0]);
        we = acc && s_axis_tuser == acm_pkg::REQ_PUSH && !output_ready;
        wdata = s_axis_tdata;
      end
      S_RDA:  maddr = idx;
      S_RDB:  maddr = idx + AW'(s);
      S_WRA:  begin maddr = idx; we = 1'b1; wdata = even_v; end
      S_WRB:  begin maddr = idx + AW'(s); we = 1'b1; wdata = odd_v; end
      S_INCR: maddr = idx;
      S_INCW: begin maddr = idx; we = 1'b1; wdata = rdata + 32'd1; end
      default: ;
    endcase
  end

  always_comb begin
    cwe = 1'b0;
    caddr = {~top, c0[BW-1:0]};
    cwdata = '0;
    case (state)
      S_CLR:  begin caddr = clr_addr; cwe = 1'b1; end
      S_CLD1: caddr = {~top, c1[BW-1:0]};
      S_CST0: begin
        cwe = 1'b1;
        cwdata = top ? {{16{p0[15]}}, p0[15:0]} : p0;
      end
      S_CST1: begin
        caddr = {~top, c1[BW-1:0]};
        cwe = 1'b1;
        cwdata = top ? {{16{p1[15]}}, p1[15:0]} : p1;
      end
      default: ;
    endcase
  end

  logic [CW-1:0] pc_next;
  always_comb pc_next = (push_count >= size ? '0 : push_count) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      levels <= '0;
      rows <= 7'd1;
      push_count <= '0;
      pull_count <= '0;
      output_ready <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_wr && (paddr == 3'd0 || paddr == 3'd4)) begin
        if (paddr == 3'd0) levels <= pwdata[3:0];
        else rows <= pwdata[6:0];
        push_count <= '0;
        pull_count <= '0;
        output_ready <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: if (acc) begin
          if (s_axis_tuser == acm_pkg::REQ_PUSH) begin
            if (output_ready) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata <= '0;
              m_axis_tlast <= 1'b0;
              m_axis_tuser <= acm_pkg::ST_PENDING;
            end else if (pc_next == size) begin
              push_count <= '0;
              pull_count <= '0;
              output_ready <= 1'b1;
              if (lv != '0) begin
                s <= (BW+1)'(1) << (lv - 1'b1);
                col <= '0;
                pidx <= '0;
                pairs <= CW'(rw);
                off <= '0;
                top <= 1'b1;
                idx <= '0;
                state <= S_CLD0;
              end else state <= S_WAIT;
            end else begin
              push_count <= pc_next;
              state <= S_WAIT;
            end
          end else if (!output_ready || pull_count >= size) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= '0;
            m_axis_tlast <= 1'b0;
            m_axis_tuser <= acm_pkg::ST_EMPTY;
          end else begin
            m_axis_tlast <= (pull_count == size - 1'b1);
            if (pull_count == size - 1'b1) begin
              output_ready <= 1'b0;
              pull_count <= '0;
            end else pull_count <= pull_count + 1'b1;
            state <= S_PULL;
          end
        end
        S_PULL: begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= rdata;
          m_axis_tuser <= acm_pkg::ST_OK;
          state <= S_IDLE;
        end
        S_WAIT: state <= S_IDLE;
        // fetch the column's carries
        S_CLD0: state <= S_CLD1;
        S_CLD1: begin p0 <= crdata; state <= S_CLD2; end
        S_CLD2: begin p1 <= crdata; state <= S_RDA; end
        S_RDA: state <= S_RDB;
        S_RDB: begin a <= rdata; state <= S_WRA; end
        S_WRA: begin b <= rdata; state <= S_WRB; end
        S_WRB: begin
          p0 <= a;
          p1 <= b;
          if (pidx + 1'b1 == pairs) state <= S_CST0;
          else begin
            pidx <= pidx + 1'b1;
            idx <= idx + AW'(s << 1);
            state <= S_RDA;
          end
        end
        S_CST0: state <= S_CST1;
        S_CST1: begin
          // carries stored, move to next column or level, to the increment pass, or finish
          pidx <= '0;
          if (col + 1'b1 != s) begin
            col <= col + 1'b1;
            idx <= AW'(col + 1'b1);
            state <= S_CLD0;
          end else if (top) begin
            idx <= '0;
            state <= S_INCR;
          end else begin
            off <= off + (s << 1);
            if (s == (BW+1)'(1)) state <= S_IDLE;
            else begin
              s <= s >> 1;
              col <= '0;
              idx <= '0;
              pairs <= pairs << 1;
              state <= S_CLD0;
            end
          end
        end
        S_INCR: state <= S_INCW;
        S_INCW: begin
          if (pidx + 1'b1 != CW'({rw, 1'b0})) begin
            pidx <= pidx + 1'b1;
            idx <= idx + AW'(s);
            state <= S_INCR;
          end else if (s == (BW+1)'(1)) state <= S_IDLE;
          else begin
            top <= 1'b0;
            s <= s >> 1;
            col <= '0;
            idx <= '0;
            pidx <= '0;
            pairs <= pairs << 1;
            off <= '0;
            state <= S_CLD0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
